/* rtl/lrmq_pkg.sv */
// Package: command codes and shared constants for the lane range max query block.
package lrmq_pkg;
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ROW   = 2'd1;
    localparam logic [1:0] CMD_EDGE  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;
    localparam int OUT_BITS = 8;
endpackage

/* rtl/lane_range_max_query_top.sv */
// Top level: row and edge tables with a sequenced range maximum query.
// A clear, an append, a refused append, or a query over an empty table or an empty range
// presents its result in the cycle after its transfer in. Any other query, after its
// transfer in, takes a step for each bucket of the range; a partial bucket then takes a
// setup step and a read and a compare step per row scanned, a bucket wholly inside the
// range a read and a compare step on its stored maximum. One more bucket step leaves the
// bucket scan; then each stored edge up to and including the first edge whose child row
// passes the clamped last row takes a read and a compare step, and one more read step ends
// the scan when it runs past the last stored edge; the result follows in the next cycle.
// Rows, bucket maxima and edges are read through the single registered read port of each
// table. The block takes no new transfer until the result has been taken, and is ready again in the cycle after that.
module lane_range_max_query_top #(
    parameter int ROW_DEPTH   = 1024,
    parameter int EDGE_DEPTH  = 1024,
    parameter int BUCKET_ROWS = 64,
    parameter int LANE_BITS   = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cmd[1:0], row_lane[9:2], edge_child[19:10], edge_parent[29:20],
    // parent_is_boundary[30], edge_lane_in[38:31], edge_child_lane_in[46:39],
    // first_row[56:47], last_row[66:57], zero fill to 72
    input  logic [71:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // max_lane[7:0]
    output logic [lrmq_pkg::OUT_BITS-1:0]   m_axis_tdata,
    // status[0]
    output logic                            m_axis_tuser
);
    import lrmq_pkg::*;

    localparam int BUCKETS = ROW_DEPTH / BUCKET_ROWS + 1;
    localparam int RW = $clog2(ROW_DEPTH + 1);
    localparam int EW = $clog2(EDGE_DEPTH + 1);
    localparam int RA = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int EA = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW = 20;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_BKT, S_RREAD, S_RCMP, S_BREAD, S_BCMP,
        S_EREAD, S_ECMP, S_OUT
    } t_state;

    t_state r_state;
    logic [LANE_BITS-1:0] lane_mem   [ROW_DEPTH];
    logic [9:0]           echild_mem [EDGE_DEPTH];
    logic [10:0]          eend_mem   [EDGE_DEPTH];
    logic [LANE_BITS-1:0] elane_mem  [EDGE_DEPTH];
    logic [LANE_BITS-1:0] eclane_mem [EDGE_DEPTH];
    logic [LANE_BITS-1:0] r_bmax [BUCKETS];

    logic [RW-1:0] r_rows;
    logic [EW-1:0] r_edges;
    logic [PW-1:0] r_first, r_last, r_pos, r_bs;
    logic [BW-1:0] r_b;
    logic [EW-1:0] r_e;
    logic [LANE_BITS-1:0] r_wide, r_rd_lane, r_rd_el, r_rd_ecl, r_rd_bmax;
    logic [9:0]  r_rd_ec;
    logic [10:0] r_rd_ee;
    logic [7:0]  r_out;
    logic        r_stat;

    logic [PW-1:0] w_be, w_to, w_lastc;
    logic [LANE_BITS-1:0] w_in_lane;
    assign w_in_lane = LANE_BITS'(s_axis_tdata[9:2]);
    assign w_be = r_bs + PW'(BUCKET_ROWS - 1);
    assign w_to = (w_be < r_last) ? w_be : r_last;
    assign w_lastc = (PW'(s_axis_tdata[66:57]) > PW'(r_rows) - PW'(1))
                   ? PW'(r_rows) - PW'(1) : PW'(s_axis_tdata[66:57]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_stat;

    logic [BW-1:0] w_ab;
    assign w_ab = BW'(PW'(r_rows) / BUCKET_ROWS);

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid && s_axis_tdata[1:0] == CMD_ROW
            && r_rows < RW'(ROW_DEPTH))
            lane_mem[RA'(r_rows)] <= w_in_lane;
        if (s_axis_tready && s_axis_tvalid && s_axis_tdata[1:0] == CMD_EDGE
            && r_edges < EW'(EDGE_DEPTH)) begin
            echild_mem[EA'(r_edges)] <= s_axis_tdata[19:10];
            eend_mem[EA'(r_edges)]   <= s_axis_tdata[30] ? 11'(s_axis_tdata[19:10]) + 11'd1
                                                         : 11'(s_axis_tdata[29:20]);
            elane_mem[EA'(r_edges)]  <= LANE_BITS'(s_axis_tdata[38:31]);
            eclane_mem[EA'(r_edges)] <= LANE_BITS'(s_axis_tdata[46:39]);
        end
        r_rd_lane <= lane_mem[RA'(r_pos)];
        r_rd_ec   <= echild_mem[EA'(r_e)];
        r_rd_ee   <= eend_mem[EA'(r_e)];
        r_rd_el   <= elane_mem[EA'(r_e)];
        r_rd_ecl  <= eclane_mem[EA'(r_e)];
        r_rd_bmax <= r_bmax[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= '0;
            r_edges <= '0;
            r_out   <= '0;
            r_stat  <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) r_bmax[i] <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_out  <= '0;
                    r_wide <= '0;
                    case (s_axis_tdata[1:0])
                        CMD_CLEAR: begin
                            r_stat  <= 1'b0;
                            r_state <= S_OUT;
                            r_rows  <= '0;
                            r_edges <= '0;
                            for (int i = 0; i < BUCKETS; i++) r_bmax[i] <= '0;
                        end
                        CMD_ROW: begin
                            r_state <= S_OUT;
                            if (r_rows >= RW'(ROW_DEPTH)) r_stat <= 1'b1;
                            else begin
                                r_stat <= 1'b0;
                                if (w_in_lane > r_bmax[w_ab]) r_bmax[w_ab] <= w_in_lane;
                                r_rows <= r_rows + RW'(1);
                            end
                        end
                        CMD_EDGE: begin
                            r_state <= S_OUT;
                            if (r_edges >= EW'(EDGE_DEPTH)) r_stat <= 1'b1;
                            else begin
                                r_stat  <= 1'b0;
                                r_edges <= r_edges + EW'(1);
                            end
                        end
                        default: begin
                            r_stat  <= 1'b0;
                            r_first <= PW'(s_axis_tdata[56:47]);
                            r_last  <= w_lastc;
                            r_e     <= '0;
                            if (r_rows != '0 && PW'(s_axis_tdata[56:47]) <= w_lastc) begin
                                r_b  <= BW'(PW'(s_axis_tdata[56:47]) / BUCKET_ROWS);
                                r_bs <= PW'((PW'(s_axis_tdata[56:47]) / BUCKET_ROWS)
                                            * BUCKET_ROWS);
                                r_state <= S_BKT;
                            end else r_state <= S_OUT;
                        end
                    endcase
                end
                S_BKT: begin
                    if (r_bs > r_last || 32'(r_b) >= BUCKETS) r_state <= S_EREAD;
                    else if (r_bs >= r_first && w_be <= r_last) r_state <= S_BREAD;
                    else begin
                        r_pos <= (r_bs > r_first) ? r_bs : r_first;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: r_state <= S_RREAD;
                S_RREAD: r_state <= S_RCMP;
                S_RCMP: begin
                    if (r_rd_lane > r_wide) r_wide <= r_rd_lane;
                    if (r_pos >= w_to) begin
                        r_b <= r_b + BW'(1);
                        r_bs <= r_bs + PW'(BUCKET_ROWS);
                        r_state <= S_BKT;
                    end else begin
                        r_pos <= r_pos + PW'(1);
                        r_state <= S_RREAD;
                    end
                end
                S_BREAD: r_state <= S_BCMP;
                S_BCMP: begin
                    if (r_rd_bmax > r_wide) r_wide <= r_rd_bmax;
                    r_b <= r_b + BW'(1);
                    r_bs <= r_bs + PW'(BUCKET_ROWS);
                    r_state <= S_BKT;
                end
                S_EREAD: begin
                    if (r_e >= r_edges) begin
                        r_out <= 8'(r_wide);
                        r_state <= S_OUT;
                    end else r_state <= S_ECMP;
                end
                S_ECMP: begin
                    if (PW'(r_rd_ec) > r_last) begin
                        r_out <= 8'(r_wide);
                        r_state <= S_OUT;
                    end else begin
                        if (PW'(r_rd_ee) >= r_first) begin
                            if (r_rd_el >= r_rd_ecl && r_rd_el > r_wide) r_wide <= r_rd_el;
                            else if (r_rd_ecl > r_rd_el && r_rd_ecl > r_wide)
                                r_wide <= r_rd_ecl;
                        end
                        r_e <= r_e + EW'(1);
                        r_state <= S_EREAD;
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* verif/lane_range_max_query_checker.sv */
// Checker: watches both streams, predicts each result of the lane range max query block and compares.
module lane_range_max_query_checker
    import lrmq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_lane,
    input  logic        i_out_status,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int ROWS    = 1024;
    localparam int EDGES   = 1024;
    localparam int BROWS   = 64;
    localparam int BUCKETS = ROWS / BROWS + 1;

    typedef struct packed {
        logic [7:0] lane;
        logic       status;
    } lane_result_t;

    logic [7:0]  row_lane_q [ROWS];
    int          row_count;
    logic [7:0]  bucket_peak [BUCKETS];
    logic [9:0]  edge_child_q [EDGES];
    logic [10:0] edge_end_q [EDGES];
    logic [7:0]  edge_lane_q [EDGES];
    logic [7:0]  edge_clane_q [EDGES];
    int          edge_count;
    lane_result_t lane_results_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = lane_results_q.size();

    function automatic logic [7:0] widest_lane(int first, int last);
        logic [7:0] w;
        int bs, be, lo, hi;
        w = '0;
        if (row_count == 0) return '0;
        if (last > row_count - 1) last = row_count - 1;
        if (first > last) return '0;
        for (int b = first / BROWS; b <= last / BROWS && b < BUCKETS; b++) begin
            bs = b * BROWS;
            be = bs + BROWS - 1;
            if (bs >= first && be <= last) begin
                if (bucket_peak[b] > w) w = bucket_peak[b];
            end else begin
                lo = bs > first ? bs : first;
                hi = be < last ? be : last;
                for (int r = lo; r <= hi && r < row_count; r++)
                    if (row_lane_q[r] > w) w = row_lane_q[r];
            end
        end
        for (int e = 0; e < edge_count; e++) begin
            if (edge_child_q[e] > last) break;
            if (edge_end_q[e] >= first) begin
                if (edge_lane_q[e] > w) w = edge_lane_q[e];
                if (edge_clane_q[e] > w) w = edge_clane_q[e];
            end
        end
        return w;
    endfunction

    task automatic predict_transfer(logic [71:0] d);
        lane_result_t res;
        res = '0;
        case (d[1:0])
            CMD_CLEAR: begin
                row_count = 0;
                edge_count = 0;
                for (int b = 0; b < BUCKETS; b++) bucket_peak[b] = '0;
            end
            CMD_ROW: begin
                if (row_count >= ROWS) res.status = 1'b1;
                else begin
                    row_lane_q[row_count] = d[9:2];
                    if (d[9:2] > bucket_peak[row_count / BROWS])
                        bucket_peak[row_count / BROWS] = d[9:2];
                    row_count++;
                end
            end
            CMD_EDGE: begin
                if (edge_count >= EDGES) res.status = 1'b1;
                else begin
                    edge_child_q[edge_count] = d[19:10];
                    edge_end_q[edge_count]   = d[30] ? {1'b0, d[19:10]} + 11'd1
                                                     : {1'b0, d[29:20]};
                    edge_lane_q[edge_count]  = d[38:31];
                    edge_clane_q[edge_count] = d[46:39];
                    edge_count++;
                end
            end
            default: res.lane = widest_lane(int'(d[56:47]), int'(d[66:57]));
        endcase
        lane_results_q = {lane_results_q, res};
    endtask

    always @(posedge i_clk) begin
        lane_result_t exp_res;
        if (!i_rst_n) begin
            row_count  <= 0;
            edge_count <= 0;
            fails      <= 0;
            for (int b = 0; b < BUCKETS; b++) bucket_peak[b] <= '0;
            lane_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (lane_results_q.size() == 0) begin
                    if (fails < 10) $display("unexpected result lane=%0d status=%0d",
                                             i_out_lane, i_out_status);
                    fails <= fails + 1;
                end else begin
                    exp_res = lane_results_q.pop_front();
                    if (exp_res.lane !== i_out_lane || exp_res.status !== i_out_status) begin
                        if (fails < 10)
                            $display("mismatch: lane exp %0d got %0d, status exp %0d got %0d",
                                     exp_res.lane, i_out_lane, exp_res.status, i_out_status);
                        fails <= fails + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_transfer(i_in_data);
        end
    end
endmodule

/* verif/lane_range_max_query_top_tb.sv */
// Testbench top: drives commands into the lane range max query block and reports the verdict.
module lane_range_max_query_top_tb;
    import lrmq_pkg::*;

    localparam int WATCHDOG = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [71:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;
    logic        m_user;
    int          fail_count, pending;
    int          idle_cycles = 0;
    int          m_hold = 0;
    int          m_gap;
    logic [9:0]  edge_floor;

    always #5 i_clk = ~i_clk;

    lane_range_max_query_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user)
    );

    lane_range_max_query_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready),
        .i_out_lane(m_data), .i_out_status(m_user),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(80, 10);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_hold > 0) begin
                m_hold  <= m_hold - 1;
                m_ready <= (m_hold == 1);
            end else if (m_valid && m_ready) begin
                m_gap = gap_len();
                m_hold  <= m_gap;
                m_ready <= (m_gap == 0);
            end else m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [71:0] pack(logic [1:0] cmd, logic [7:0] rl, logic [9:0] ch,
                                         logic [9:0] par, logic bnd, logic [7:0] el,
                                         logic [7:0] ecl, logic [9:0] fr, logic [9:0] lr);
        return {5'd0, lr, fr, ecl, el, bnd, par, ch, rl, cmd};
    endfunction

    task automatic send(logic [71:0] d);
        repeat (gap_len() + 1) @(posedge i_clk);
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        s_valid <= 1'b0;
    endtask

    task automatic send_row(logic [7:0] lane);
        send(pack(CMD_ROW, lane, 10'($urandom), 10'($urandom), 1'($urandom), 8'($urandom),
                  8'($urandom), 10'($urandom), 10'($urandom)));
    endtask

    task automatic send_edge(logic [9:0] ch, logic [9:0] par, logic bnd,
                             logic [7:0] el, logic [7:0] ecl);
        send(pack(CMD_EDGE, 8'($urandom), ch, par, bnd, el, ecl, 10'($urandom),
                  10'($urandom)));
    endtask

    task automatic send_query(logic [9:0] fr, logic [9:0] lr);
        send(pack(CMD_QUERY, 8'($urandom), 10'($urandom), 10'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom), fr, lr));
    endtask

    task automatic send_clear();
        send(pack(CMD_CLEAR, 8'($urandom), 10'($urandom), 10'($urandom), 1'($urandom),
                  8'($urandom), 8'($urandom), 10'($urandom), 10'($urandom)));
    endtask

    task automatic random_query();
        logic [9:0] f, l;
        f = $urandom_range(99) < 10 ? 10'($urandom) : 10'($urandom_range(200));
        l = $urandom_range(99) < 15 ? 10'($urandom) : 10'(f + $urandom_range(130));
        send_query(f, l);
    endtask

    initial begin
        int op;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, boundary edge, parent before child
        send_query(10'd0, 10'd1023);
        send_edge(10'd0, 10'd0, 1'b1, 8'd0, 8'd0);
        send_query(10'd0, 10'd0);
        send_clear();
        send_row(8'd0);
        send_row(8'd255);
        send_row(8'd7);
        send_query(10'd0, 10'd1023);
        send_query(10'd2, 10'd1);
        send_query(10'd1023, 10'd1023);
        send_edge(10'd1, 10'd1023, 1'b0, 8'd200, 8'd9);
        send_edge(10'd2, 10'd0, 1'b0, 8'd255, 8'd255);
        send_edge(10'd1023, 10'd5, 1'b1, 8'd3, 8'd4);
        send_edge(10'd0, 10'd0, 1'b0, 8'd250, 8'd1);
        send_query(10'd2, 10'd2);
        send_query(10'd1, 10'd1);
        send_clear();
        for (int i = 0; i < 130; i++) send_row(8'($urandom));
        send_query(10'd0, 10'd127);
        send_query(10'd3, 10'd129);
        wait (pending == 0);

        // fill the edge table to capacity and beyond
        send_clear();
        for (int i = 0; i < 100; i++)
            send_row($urandom_range(99) < 3 ? 8'd255 : 8'($urandom));
        edge_floor = '0;
        for (int i = 0; i < 1026; i++) begin
            if ($urandom_range(99) < 2) edge_floor = edge_floor + 10'd1;
            send_edge(edge_floor, 10'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        end
        for (int i = 0; i < 20; i++) random_query();
        send_query(10'd0, 10'd1023);
        send_query(10'd1023, 10'd1023);
        wait (pending == 0);
        send_clear();

        // random: mostly sorted edges over small tables
        edge_floor = '0;
        for (int i = 0; i < 120; i++) begin
            op = $urandom_range(99);
            if (op < 2) begin
                send_clear();
                edge_floor = '0;
            end else if (op < 45) send_row(8'($urandom));
            else if (op < 65) begin
                if ($urandom_range(99) < 90) begin
                    edge_floor = 10'(edge_floor + $urandom_range(3));
                    send_edge(edge_floor, 10'(edge_floor + $urandom_range(20)),
                              1'($urandom), 8'($urandom), 8'($urandom));
                end else send_edge(10'($urandom), 10'($urandom), 1'($urandom),
                                   8'($urandom), 8'($urandom));
            end else random_query();
            if (i == 60) wait (pending == 0);
        end

        wait (pending == 0);
        repeat (3000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

/* lane_range_max_query_top.f */
rtl/lrmq_pkg.sv
rtl/lane_range_max_query_top.sv
verif/lane_range_max_query_checker.sv
verif/lane_range_max_query_top_tb.sv
